@@ rtl/imi_pkg.sv @@
`timescale 1ns / 1ps
// imi_pkg: shared types and constants of the indent marker inserter
// no dependencies; imported by every rtl module

package imi_pkg;

  // character codes
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] MarkIndent = 8'h12;
  localparam logic [7:0] MarkDedent = 8'h14;

  // tab width register
  localparam int unsigned TabBits  = 4;
  localparam logic [TabBits-1:0] TabReset = 4'd4;

  // depth of the queue between classifier and emitter
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    MK_NONE   = 2'd0,
    MK_INDENT = 2'd1,
    MK_DEDENT = 2'd2
  } mark_e;

  // one classified beat: optional marker, then the byte (or end-only)
  typedef struct packed {
    mark_e      mark;
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } entry_t;

  // queue write side
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // queue read side
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

@@ rtl/imi_stream_if.sv @@
`timescale 1ns / 1ps
// imi_in_if / imi_out_if: valid/ready stream channels of the inserter
// depends on nothing; payload widths fixed by the text format

interface imi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface imi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output has_byte, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input out_last,
                  output ready);
endinterface

@@ rtl/imi_front.sv @@
`timescale 1ns / 1ps
// imi_front: accepts text beats, sums leading indent, classifies lines
// depends on imi_pkg and imi_in_if; writes entries into imi_queue

module imi_front
  import imi_pkg::*;
#(
  parameter int unsigned INDENT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TabBits-1:0] cfg_data_i,
  imi_in_if.sink             in_i,
  input  logic               full_i,
  output push_t              push_o
);

  localparam int unsigned SumW = INDENT_BITS + 1;

  logic                   line_start_q, line_start_d;
  logic [INDENT_BITS-1:0] cur_q, cur_d;
  logic [INDENT_BITS-1:0] prev_q, prev_d;
  logic [TabBits-1:0]     tab_q;

  logic                   accept;
  logic                   is_ws;
  logic [TabBits-1:0]     addend;
  logic [SumW-1:0]        sum;
  logic [INDENT_BITS-1:0] sat_sum;
  mark_e                  mark;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & ~full_i;

  // leading whitespace and saturating indent sum
  assign is_ws   = line_start_q & ((in_i.in_byte == ChSpace) | (in_i.in_byte == ChTab));
  assign addend  = (in_i.in_byte == ChSpace) ? TabBits'(1) : tab_q;
  assign sum     = SumW'(cur_q) + SumW'(addend);
  assign sat_sum = sum[INDENT_BITS] ? '1 : sum[INDENT_BITS-1:0];

  // marker decision at the first other byte of a line
  always_comb begin
    priority if (!line_start_q) begin
      mark = MK_NONE;
    end else if (cur_q < prev_q) begin
      mark = MK_DEDENT;
    end else if (cur_q > prev_q) begin
      mark = MK_INDENT;
    end else begin
      mark = MK_NONE;
    end
  end

  // queue entry
  always_comb begin
    push_o.valid = accept & (~is_ws | in_i.in_last);
    if (is_ws) begin
      push_o.entry.mark     = MK_NONE;
      push_o.entry.data     = '0;
      push_o.entry.has_byte = 1'b0;
    end else begin
      push_o.entry.mark     = mark;
      push_o.entry.data     = in_i.in_byte;
      push_o.entry.has_byte = 1'b1;
    end
    push_o.entry.last = in_i.in_last;
  end

  // line state update
  always_comb begin
    line_start_d = line_start_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    if (accept) begin
      if (in_i.in_last) begin
        line_start_d = 1'b1;
        cur_d        = '0;
        prev_d       = '0;
      end else if (is_ws) begin
        cur_d = sat_sum;
      end else begin
        if (line_start_q) begin
          prev_d = cur_q;
          cur_d  = '0;
        end
        line_start_d = (in_i.in_byte == ChNewline);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= 1'b1;
      cur_q        <= '0;
      prev_q       <= '0;
      tab_q        <= TabReset;
    end else begin
      line_start_q <= line_start_d;
      cur_q        <= cur_d;
      prev_q       <= prev_d;
      if (cfg_we_i) begin
        tab_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ rtl/imi_queue.sv @@
`timescale 1ns / 1ps
// imi_queue: short fifo of classified entries between front and back
// depends on imi_pkg

module imi_queue
  import imi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output head_t head_o,
  input  logic  pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  assign do_push = push_i.valid & ~full_o;
  assign do_pop  = pop_i & head_o.valid;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/imi_back.sv @@
`timescale 1ns / 1ps
// imi_back: expands queue entries into output beats, marker first
// depends on imi_pkg and imi_out_if; reads entries from imi_queue

module imi_back
  import imi_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  head_t      head_i,
  output logic       pop_o,
  imi_out_if.source  out_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       has_q;
  logic       last_q;
  logic       mark_sent_q;

  logic       load;
  logic       send_mark;
  logic [7:0] mark_byte;

  assign load      = ~valid_q | out_o.ready;
  assign send_mark = (head_i.entry.mark != MK_NONE) & ~mark_sent_q;
  assign pop_o     = load & head_i.valid & ~send_mark;

  always_comb begin
    unique case (head_i.entry.mark)
      MK_INDENT: mark_byte = MarkIndent;
      MK_DEDENT: mark_byte = MarkDedent;
      default:   mark_byte = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      mark_sent_q <= 1'b0;
    end else if (load) begin
      valid_q <= head_i.valid;
      if (head_i.valid) begin
        mark_sent_q <= send_mark;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load && head_i.valid) begin
      if (send_mark) begin
        byte_q <= mark_byte;
        has_q  <= 1'b1;
        last_q <= 1'b0;
      end else begin
        byte_q <= head_i.entry.data;
        has_q  <= head_i.entry.has_byte;
        last_q <= head_i.entry.last;
      end
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = byte_q;
  assign out_o.has_byte = has_q;
  assign out_o.out_last = last_q;

endmodule

@@ rtl/indent_marker_inserter_top.sv @@
`timescale 1ns / 1ps
// path: input beats are queued; their result beats leave through the output register
// throughput: one input beat per cycle unless the queue is full; a marker adds one output beat
// the four-entry queue between classifier and emitter absorbs marker cycles and output stalls
// reset: rst_ni async low clears line state, queue and output; tab width returns to 4
// depends on imi_pkg, imi_stream_if, imi_front, imi_queue, imi_back

module indent_marker_inserter_top
  import imi_pkg::*;
#(
  parameter int unsigned INDENT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [TabBits-1:0] cfg_data_i,
  imi_in_if.sink             in_i,
  imi_out_if.source          out_o
);

  push_t push;
  head_t head;
  logic  full;
  logic  pop;

  imi_front #(
    .INDENT_BITS(INDENT_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_i),
    .full_i    (full),
    .push_o    (push)
  );

  imi_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .full_o(full),
    .head_o(head),
    .pop_i (pop)
  );

  imi_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .head_i(head),
    .pop_o (pop),
    .out_o (out_o)
  );

endmodule

@@ rtl/imi_checker.sv @@
`timescale 1ns / 1ps
// imi_checker: port-level checks on the output channel of the inserter
// depends on imi_pkg; bound to indent_marker_inserter_top below

module imi_checker
  import imi_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       has_byte_i,
  input logic       out_last_i
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(has_byte_i) && $stable(out_last_i))
    else $error("stalled output beat changed");

  // an end-only beat always closes the text
  a_end_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_byte_i |-> out_last_i)
    else $error("end-only beat without last");

  // an end-only beat carries a zero byte
  a_end_only_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_byte_i |-> out_byte_i == '0)
    else $error("end-only beat with nonzero byte");

  // no output beat is offered while reset is held
  a_idle_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output beat offered during reset");

endmodule

bind indent_marker_inserter_top imi_checker u_imi_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_byte_i (out_o.out_byte),
  .has_byte_i (out_o.has_byte),
  .out_last_i (out_o.out_last)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench of indent_marker_inserter_top, beats checked against a predictor
// depends on imi_pkg, imi_stream_if and the rtl below indent_marker_inserter_top

module testbench
  import imi_pkg::*;
();

  localparam int unsigned IndentBits  = 16;
  localparam int          HalfPeriod  = 5;
  localparam int          ResetCycles = 6;
  localparam int          IdlePad     = 8;
  localparam int          StallBurst  = 300;
  localparam int          WatchdogMax = 2000;
  localparam int          PhaseBeats  = 305;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } out_beat_t;

  // one text beat on the input channel
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } text_beat_t;

  // directed row: beat, and optionally the result beats typed in by hand
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    logic [1:0] n;
    out_beat_t  r0;
    out_beat_t  r1;
  } dir_row_t;

  localparam out_beat_t NoBeat = '{8'h00, 1'b0, 1'b0};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [TabBits-1:0]  cfg_data_i;

  imi_in_if  in_ch ();
  imi_out_if out_ch ();

  indent_marker_inserter_top #(
    .INDENT_BITS(IndentBits)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // predictor state and the queue of result beats still to come
  logic [TabBits-1:0]    tab_w;
  logic                  line_start;
  logic [IndentBits-1:0] cur_indent;
  logic [IndentBits-1:0] prev_indent;
  out_beat_t             expected_beats[$];
  text_beat_t            text_q[$];

  int  mismatches   = 0;
  int  beats_in     = 0;
  int  beats_out    = 0;
  int  indent_marks = 0;
  int  dedent_marks = 0;
  int  end_only     = 0;
  int  tab_settings = 0;
  bit  src_quiet = 1'b0;
  bit  snk_quiet = 1'b0;
  bit  burst_req = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic clear_line_state();
    line_start  = 1'b1;
    cur_indent  = '0;
    prev_indent = '0;
  endtask

  // work out the result beats one text beat causes, and advance the line state
  task automatic predict_text_beat(input logic [7:0] b, input logic last, output int n,
                                   output out_beat_t r0, output out_beat_t r1);
    logic [IndentBits:0]  sum;
    logic [TabBits-1:0]   step;
    out_beat_t            copy;
    n  = 0;
    r0 = NoBeat;
    r1 = NoBeat;
    if (line_start && (b == ChSpace || b == ChTab)) begin
      // leading whitespace is swallowed into the indent, saturating
      step = (b == ChSpace) ? TabBits'(1) : tab_w;
      sum  = {1'b0, cur_indent} + (IndentBits + 1)'(step);
      cur_indent = sum[IndentBits] ? '1 : sum[IndentBits-1:0];
      if (last) begin
        n  = 1;
        r0 = '{8'h00, 1'b0, 1'b1};
        end_only++;
        clear_line_state();
      end
    end else begin
      // first byte of a line decides the marker
      if (line_start) begin
        if (cur_indent < prev_indent) begin
          r0 = '{MarkDedent, 1'b1, 1'b0};
          n  = 1;
          dedent_marks++;
        end else if (cur_indent > prev_indent) begin
          r0 = '{MarkIndent, 1'b1, 1'b0};
          n  = 1;
          indent_marks++;
        end
        prev_indent = cur_indent;
        cur_indent  = '0;
      end
      copy = '{b, 1'b1, last};
      if (n == 0) r0 = copy;
      else r1 = copy;
      n++;
      line_start = (b == ChNewline);
      if (last) clear_line_state();
    end
  endtask

  // offer one text beat, wait for it to be taken, then queue what it should cause
  task automatic send_beat(input logic [7:0] b, input logic last, input logic typed,
                           input logic [1:0] n_typed, input out_beat_t t0, input out_beat_t t1);
    int        gap;
    int        n;
    out_beat_t p0;
    out_beat_t p1;
    gap = src_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    beats_in++;
    predict_text_beat(b, last, n, p0, p1);
    if (typed) begin
      n  = n_typed;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) expected_beats.push_back(p0);
    if (n > 1) expected_beats.push_back(p1);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_beat(text_q[i].b, text_q[i].last, 1'b0, 2'd0, NoBeat, NoBeat);
  endtask

  // let everything drain, then an idle pad for a swallowed beat still in flight
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (IdlePad) @(posedge clk_i);
  endtask

  task automatic write_tab_width(input logic [TabBits-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tab_w = value;
    tab_settings++;
  endtask

  // leading whitespace of one line: spaces, tabs or a mix, now and then a long run
  task automatic add_indent();
    int lvl;
    int style;
    int nws;
    lvl   = $urandom_range(0, 4);
    style = $urandom_range(0, 3);
    nws   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) :
            (style == 2) ? lvl : lvl * 2;
    repeat (nws) begin
      if (style == 3) text_q.push_back('{($urandom_range(0, 1) != 0) ? ChTab : ChSpace, 1'b0});
      else if (style == 2) text_q.push_back('{ChTab, 1'b0});
      else text_q.push_back('{ChSpace, 1'b0});
    end
  endtask

  // line body: mostly printable, sometimes any byte but a newline
  task automatic add_body();
    int         nbody;
    logic [7:0] b;
    nbody = $urandom_range(0, 6);
    repeat (nbody) begin
      if ($urandom_range(0, 5) == 0) begin
        b = 8'($urandom);
        if (b == ChNewline) b = 8'h0B;
      end else begin
        b = 8'($urandom_range(8'h21, 8'h7E));
      end
      text_q.push_back('{b, 1'b0});
    end
  endtask

  // one whole text: a few lines with varying indent, or a burst of raw bytes
  task automatic build_text();
    int lines;
    int nraw;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      nraw = $urandom_range(1, 12);
      repeat (nraw) text_q.push_back('{8'($urandom), 1'b0});
    end else begin
      lines = $urandom_range(1, 5);
      repeat (lines) begin
        add_indent();
        add_body();
        text_q.push_back('{ChNewline, 1'b0});
      end
      case ($urandom_range(0, 3))
        1: begin
          // unterminated last line
          add_body();
          text_q.push_back('{8'($urandom_range(8'h21, 8'h7E)), 1'b0});
        end
        2: begin
          // final line of whitespace only
          nraw = $urandom_range(1, 3);
          repeat (nraw) text_q.push_back('{($urandom_range(0, 1) != 0) ? ChTab : ChSpace, 1'b0});
        end
        3: begin
          add_indent();
          text_q.push_back('{8'($urandom_range(8'h21, 8'h7E)), 1'b0});
        end
        default: begin
        end
      endcase
    end
    text_q[text_q.size()-1].last = 1'b1;
  endtask

  task automatic run_phase(input logic [TabBits-1:0] tw_val, input bit pressure);
    int sent;
    settle_block();
    write_tab_width(tw_val);
    if (pressure) begin
      src_quiet = 1'b1;
      snk_quiet = 1'b0;
      burst_req = 1'b1;
    end else begin
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet = ($urandom_range(0, 3) == 0);
    end
    sent = 0;
    while (sent < PhaseBeats) begin
      build_text();
      send_text();
      sent += text_q.size();
    end
  endtask

  // result side: random hold-offs, one long hold on request, check every beat
  initial begin : result_sink
    out_beat_t got;
    out_beat_t want;
    int        gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = snk_quiet ? 0 : $urandom_range(0, 14);
      if (burst_req) begin
        gap       = StallBurst;
        burst_req = 1'b0;
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      beats_out++;
      got = '{out_ch.out_byte, out_ch.has_byte, out_ch.out_last};
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("result beat %02h/%0b/%0b with nothing expected",
                                  got.data, got.has_byte, got.last));
      end else begin
        want = expected_beats.pop_front();
        if (got.data !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", got.data, want.data));
        if (got.has_byte !== want.has_byte)
          report_mismatch($sformatf("has_byte %0b, expected %0b", got.has_byte, want.has_byte));
        if (got.last !== want.last)
          report_mismatch($sformatf("out_last %0b, expected %0b", got.last, want.last));
      end
    end
  end

  // watchdog: too long without any beat moving ends the run
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogMax) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no beat moved for %0d cycles", WatchdogMax);
    $display("indent_marker_inserter_top test failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    dir_row_t dir_rows [23];
    // directed rows, tab width 4 after reset
    dir_rows = '{
      '{ChSpace,   1'b0, 1'b1, 2'd0, NoBeat, NoBeat},
      '{ChTab,     1'b0, 1'b1, 2'd0, NoBeat, NoBeat},
      '{8'h61,     1'b0, 1'b1, 2'd2, '{MarkIndent, 1'b1, 1'b0}, '{8'h61, 1'b1, 1'b0}},
      '{ChNewline, 1'b0, 1'b1, 2'd1, '{ChNewline, 1'b1, 1'b0}, NoBeat},
      '{8'h62,     1'b0, 1'b1, 2'd2, '{MarkDedent, 1'b1, 1'b0}, '{8'h62, 1'b1, 1'b0}},
      '{8'hFF,     1'b0, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b0}, NoBeat},
      '{ChNewline, 1'b0, 1'b1, 2'd1, '{ChNewline, 1'b1, 1'b0}, NoBeat},
      '{ChNewline, 1'b0, 1'b1, 2'd1, '{ChNewline, 1'b1, 1'b0}, NoBeat},
      '{8'h00,     1'b0, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b0}, NoBeat},
      '{MarkIndent, 1'b0, 1'b1, 2'd1, '{MarkIndent, 1'b1, 1'b0}, NoBeat},
      '{ChNewline, 1'b0, 1'b1, 2'd1, '{ChNewline, 1'b1, 1'b0}, NoBeat},
      '{ChSpace,   1'b0, 1'b1, 2'd0, NoBeat, NoBeat},
      '{ChSpace,   1'b1, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1}, NoBeat},
      '{8'h78,     1'b1, 1'b1, 2'd1, '{8'h78, 1'b1, 1'b1}, NoBeat},
      '{ChTab,     1'b0, 1'b1, 2'd0, NoBeat, NoBeat},
      '{ChTab,     1'b0, 1'b1, 2'd0, NoBeat, NoBeat},
      '{MarkDedent, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
      '{ChSpace,   1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
      '{ChNewline, 1'b0, 1'b0, 2'd0, NoBeat, NoBeat},
      '{8'h63,     1'b1, 1'b1, 2'd2, '{MarkDedent, 1'b1, 1'b0}, '{8'h63, 1'b1, 1'b1}},
      '{ChNewline, 1'b1, 1'b1, 2'd1, '{ChNewline, 1'b1, 1'b1}, NoBeat},
      '{ChSpace,   1'b0, 1'b1, 2'd0, NoBeat, NoBeat},
      '{8'h80,     1'b1, 1'b1, 2'd2, '{MarkIndent, 1'b1, 1'b0}, '{8'h80, 1'b1, 1'b1}}
    };

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_data_i    <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    tab_w = TabReset;
    clear_line_state();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_rows[i])
      send_beat(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].n,
                dir_rows[i].r0, dir_rows[i].r1);

    // random texts over several tab widths, the extremes and one long output hold
    run_phase(4'd0, 1'b0);
    run_phase(4'd15, 1'b0);
    run_phase(TabBits'($urandom_range(1, 14)), 1'b1);
    run_phase(4'd1, 1'b0);
    run_phase(TabBits'($urandom), 1'b0);
    run_phase(TabBits'($urandom), 1'b0);

    settle_block();
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));

    $display("run: %0d text beats in, %0d result beats out, %0d tab width settings",
             beats_in, beats_out, tab_settings);
    $display("run: %0d indent and %0d dedent markers, %0d end-only beats",
             indent_marks, dedent_marks, end_only);
    if (mismatches == 0) begin
      $display("indent_marker_inserter_top test passed");
    end else begin
      $display("indent_marker_inserter_top test failed");
    end
    $finish;
  end

endmodule
